### sv/scbp_pkg.sv
// Shared types and constants of the serial controller bit port.
package scbp_pkg;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RECV  = 2'd2,
      OP_TAKE  = 2'd3
   } op_type;

   localparam int unsigned BIT_INDEX_W = 5;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RX_RATE_W   = 11;
   localparam int unsigned TX_RATE_W   = 12;
   localparam int unsigned LOAD_W      = 4;
   localparam int unsigned ENABLE_W    = 4;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned REQ_USER_W  = 2;
   localparam int unsigned RSP_DATA_W  = 16;
   localparam int unsigned RSP_USER_W  = 1;

   localparam logic [BIT_INDEX_W-1:0] BIT_TOP_BYTE    = 5'd7;
   localparam logic [BIT_INDEX_W-1:0] BIT_ERR_SUMMARY = 5'd9;
   localparam logic [BIT_INDEX_W-1:0] BIT_TOP_RX_RATE = 5'd10;
   localparam logic [BIT_INDEX_W-1:0] BIT_TOP_TX_RATE = 5'd11;
   localparam logic [BIT_INDEX_W-1:0] BIT_LOAD_TXR    = 5'd11;
   localparam logic [BIT_INDEX_W-1:0] BIT_LOAD_RXR    = 5'd12;
   localparam logic [BIT_INDEX_W-1:0] BIT_LOAD_INTV   = 5'd13;
   localparam logic [BIT_INDEX_W-1:0] BIT_LOAD_CTRL   = 5'd14;
   localparam logic [BIT_INDEX_W-1:0] BIT_RX_IRQ      = 5'd16;
   localparam logic [BIT_INDEX_W-1:0] BIT_TX_IRQ      = 5'd17;
   localparam logic [BIT_INDEX_W-1:0] BIT_RTS         = 5'd16;
   localparam logic [BIT_INDEX_W-1:0] BIT_BREAK       = 5'd17;
   localparam logic [BIT_INDEX_W-1:0] BIT_EN_RX       = 5'd18;
   localparam logic [BIT_INDEX_W-1:0] BIT_EN_TX       = 5'd19;
   localparam logic [BIT_INDEX_W-1:0] BIT_EN_TIMER    = 5'd20;
   localparam logic [BIT_INDEX_W-1:0] BIT_EN_DSET     = 5'd21;
   localparam logic [BIT_INDEX_W-1:0] BIT_RX_LOADED   = 5'd21;
   localparam logic [BIT_INDEX_W-1:0] BIT_TX_EMPTY    = 5'd22;
   localparam logic [BIT_INDEX_W-1:0] BIT_SHIFT_EMPTY = 5'd23;
   localparam logic [BIT_INDEX_W-1:0] BIT_RTS_READ    = 5'd26;
   localparam logic [BIT_INDEX_W-1:0] BIT_LOAD_STATUS = 5'd30;
   localparam logic [BIT_INDEX_W-1:0] BIT_RESET       = 5'd31;

   localparam int unsigned LD_CTRL  = 0;
   localparam int unsigned LD_INTV  = 1;
   localparam int unsigned LD_RXR   = 2;
   localparam int unsigned LD_TXR   = 3;
   localparam int unsigned EN_RX    = 0;
   localparam int unsigned EN_TX    = 1;
   localparam int unsigned EN_TIMER = 2;
   localparam int unsigned EN_DSET  = 3;

   typedef struct packed {
      op_type                  operation;
      logic [BIT_INDEX_W-1:0]  bit_index;
      logic [BYTE_W-1:0]       data;
   } req_item_type;

   typedef struct packed {
      logic              read_bit;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              irq;
   } rsp_item_type;

endpackage

### sv/scbp_core.sv
// Register file of the controller and the per-transaction update and result logic.
module scbp_core
   import scbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [BYTE_W-1:0]    control_ff, control_in;
   logic [BYTE_W-1:0]    interval_ff, interval_in;
   logic [RX_RATE_W-1:0] rx_rate_ff, rx_rate_in;
   logic [TX_RATE_W-1:0] tx_rate_ff, tx_rate_in;
   logic [BYTE_W-1:0]    rx_buffer_ff, rx_buffer_in;
   logic [BYTE_W-1:0]    tx_buffer_ff, tx_buffer_in;
   logic [LOAD_W-1:0]    load_ff, load_in;
   logic [ENABLE_W-1:0]  enables_ff, enables_in;
   logic tx_empty_ff, tx_empty_in;
   logic shift_empty_ff, shift_empty_in;
   logic rx_loaded_ff, rx_loaded_in;
   logic overrun_ff, overrun_in;
   logic tx_pending_ff, tx_pending_in;
   logic rts_ff, rts_in;
   logic break_ff, break_in;

   logic                   wv;
   logic [BIT_INDEX_W-1:0] bi;
   logic                   rx_irq;
   logic                   tx_irq;
   logic                   rd;

   assign wv     = item.data[0];
   assign bi     = item.bit_index;
   assign rx_irq = rx_loaded_ff && enables_ff[EN_RX];
   assign tx_irq = tx_empty_ff && enables_ff[EN_TX];

   always_comb begin
      rd = 1'b0;
      case (bi) inside
         [5'd0:BIT_TOP_BYTE]: rd = rx_buffer_ff[bi[2:0]];
         BIT_ERR_SUMMARY:     rd = overrun_ff;
         BIT_TOP_TX_RATE:     rd = overrun_ff;
         BIT_RX_IRQ:          rd = rx_irq;
         BIT_TX_IRQ:          rd = tx_irq;
         BIT_RX_LOADED:       rd = rx_loaded_ff;
         BIT_TX_EMPTY:        rd = tx_empty_ff;
         BIT_SHIFT_EMPTY:     rd = shift_empty_ff;
         BIT_RTS_READ:        rd = rts_ff;
         BIT_LOAD_STATUS:     rd = (load_ff != '0) || break_ff;
         BIT_RESET:           rd = rx_irq || tx_irq;
         default:             rd = 1'b0;
      endcase
   end

   always_comb begin
      control_in     = control_ff;
      interval_in    = interval_ff;
      rx_rate_in     = rx_rate_ff;
      tx_rate_in     = tx_rate_ff;
      rx_buffer_in   = rx_buffer_ff;
      tx_buffer_in   = tx_buffer_ff;
      load_in        = load_ff;
      enables_in     = enables_ff;
      tx_empty_in    = tx_empty_ff;
      shift_empty_in = shift_empty_ff;
      rx_loaded_in   = rx_loaded_ff;
      overrun_in     = overrun_ff;
      tx_pending_in  = tx_pending_ff;
      rts_in         = rts_ff;
      break_in       = break_ff;
      result.read_bit = 1'b0;
      result.tx_valid = 1'b0;
      result.tx_byte  = '0;
      case (item.operation)
         OP_READ: begin
            result.read_bit = rd;
         end
         OP_WRITE: begin
            if (bi == BIT_RESET) begin
               control_in     = '0;
               interval_in    = '0;
               rx_rate_in     = '0;
               tx_rate_in     = '0;
               rx_buffer_in   = '0;
               tx_buffer_in   = '0;
               load_in        = '1;
               enables_in     = '0;
               tx_empty_in    = 1'b1;
               shift_empty_in = 1'b1;
               rx_loaded_in   = 1'b0;
               overrun_in     = 1'b0;
               tx_pending_in  = 1'b0;
               rts_in         = 1'b0;
               break_in       = 1'b0;
            end else if (bi <= BIT_TOP_TX_RATE && load_ff != '0) begin
               if (load_ff[LD_CTRL] && bi <= BIT_TOP_BYTE) begin
                  control_in[bi[2:0]] = wv;
                  if (bi == BIT_TOP_BYTE) load_in[LD_CTRL] = 1'b0;
               end
               if (load_ff[LD_INTV] && bi <= BIT_TOP_BYTE) begin
                  interval_in[bi[2:0]] = wv;
                  if (bi == BIT_TOP_BYTE) load_in[LD_INTV] = 1'b0;
               end
               if (load_ff[LD_RXR] && bi <= BIT_TOP_RX_RATE) begin
                  rx_rate_in[bi[3:0]] = wv;
                  if (bi == BIT_TOP_RX_RATE) load_in[LD_RXR] = 1'b0;
               end
               if (load_ff[LD_TXR]) begin
                  tx_rate_in[bi[3:0]] = wv;
                  if (bi == BIT_TOP_TX_RATE) load_in[LD_TXR] = 1'b0;
               end
            end else if (bi <= BIT_TOP_BYTE) begin
               tx_buffer_in[bi[2:0]] = wv;
               if (bi == BIT_TOP_BYTE) begin
                  tx_empty_in   = 1'b0;
                  tx_pending_in = 1'b1;
               end
            end else begin
               case (bi)
                  BIT_LOAD_TXR:  load_in[LD_TXR]  = wv;
                  BIT_LOAD_RXR:  load_in[LD_RXR]  = wv;
                  BIT_LOAD_INTV: load_in[LD_INTV] = wv;
                  BIT_LOAD_CTRL: load_in[LD_CTRL] = wv;
                  BIT_RTS:       rts_in = wv;
                  BIT_BREAK:     break_in = wv;
                  BIT_EN_RX: begin
                     enables_in[EN_RX] = wv;
                     rx_loaded_in      = 1'b0;
                  end
                  BIT_EN_TX:     enables_in[EN_TX]    = wv;
                  BIT_EN_TIMER:  enables_in[EN_TIMER] = wv;
                  BIT_EN_DSET:   enables_in[EN_DSET]  = wv;
                  default: ;
               endcase
            end
         end
         OP_RECV: begin
            if (rx_loaded_ff) overrun_in = 1'b1;
            rx_buffer_in = item.data;
            rx_loaded_in = 1'b1;
         end
         OP_TAKE: begin
            if (tx_pending_ff) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = tx_buffer_ff;
               tx_pending_in   = 1'b0;
               tx_empty_in     = 1'b1;
               shift_empty_in  = 1'b1;
            end
         end
         default: ;
      endcase
      result.irq = (rx_loaded_in && enables_in[EN_RX]) || (tx_empty_in && enables_in[EN_TX]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff     <= '0;
         interval_ff    <= '0;
         rx_rate_ff     <= '0;
         tx_rate_ff     <= '0;
         rx_buffer_ff   <= '0;
         tx_buffer_ff   <= '0;
         load_ff        <= '1;
         enables_ff     <= '0;
         tx_empty_ff    <= 1'b1;
         shift_empty_ff <= 1'b1;
         rx_loaded_ff   <= 1'b0;
         overrun_ff     <= 1'b0;
         tx_pending_ff  <= 1'b0;
         rts_ff         <= 1'b0;
         break_ff       <= 1'b0;
      end else if (fire) begin
         control_ff     <= control_in;
         interval_ff    <= interval_in;
         rx_rate_ff     <= rx_rate_in;
         tx_rate_ff     <= tx_rate_in;
         rx_buffer_ff   <= rx_buffer_in;
         tx_buffer_ff   <= tx_buffer_in;
         load_ff        <= load_in;
         enables_ff     <= enables_in;
         tx_empty_ff    <= tx_empty_in;
         shift_empty_ff <= shift_empty_in;
         rx_loaded_ff   <= rx_loaded_in;
         overrun_ff     <= overrun_in;
         tx_pending_ff  <= tx_pending_in;
         rts_ff         <= rts_in;
         break_ff       <= break_in;
      end
   end

endmodule

### sv/serial_controller_bit_port_unit.sv
// Top level of the serial controller bit port with its input and result registers.
//
// The block takes one transaction per cycle on req_ while rsp_ flows: req_tuser carries the
// operation (bit read, bit write, received byte, take transmit byte) and req_tdata the
// bit index and data byte. Each transaction yields exactly one rsp_ transaction holding
// the read bit, the handed-out transmit byte with its valid flag in rsp_tuser, and the
// interrupt line as it stands after the operation.
// A transaction is first captured in an input register. Once the output register is free
// or being taken, the register file is read, updated and the result is captured in the
// output register, which drives rsp_tvalid. The throughput is one transaction per cycle
// while rsp_ does not stall, set by the single read-modify-write of the flag registers.
// When the receiver holds rsp_tready low, the output register keeps its result, the
// item in the input register waits, and req_tready falls once that register is full;
// nothing is lost or repeated. Reset clears both stages and puts the register file in
// its power-up state: all load flags set, transmitter and shift register empty, all
// other registers zero. A write of bit 31 has the same effect on the register file.
module serial_controller_bit_port_unit
   import scbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // bit_index [4:0], data [12:5], zero [15:13]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation [1:0]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // read_bit [0], tx_byte [8:1], irq [9], zero [15:10]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // tx_valid [0]
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type result;
   logic         fire;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   scbp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.operation <= op_type'(req_tuser[1:0]);
         in_item_ff.bit_index <= req_tdata[BIT_INDEX_W-1:0];
         in_item_ff.data      <= req_tdata[BIT_INDEX_W+BYTE_W-1:BIT_INDEX_W];
      end
      if (fire) out_item_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_item_ff.irq, out_item_ff.tx_byte, out_item_ff.read_bit};
   assign rsp_tuser  = out_item_ff.tx_valid;

endmodule
